// ===== sv/fcb_pkg.sv =====
// shared types, codes and constants for the failure circuit breaker
`default_nettype none

package fcb_pkg;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned TIME_W   = 48;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned PROBE_W  = 2;
    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned RECOV_W  = 32;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    // actions
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SUCCESS = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FAILURE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd3;

    // breaker modes
    localparam logic [MODE_W-1:0] MODE_CLOSED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HALF   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_MS   = 1'd1;

    localparam logic [PROBE_W-1:0] CLOSE_SUCCESSES = 2'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_RST       = 16'd5;
    localparam logic [RECOV_W-1:0] RECOVERY_RST    = 32'd30000;

    typedef struct packed {
        logic [LIMIT_W-1:0] failure_limit;
        logic [RECOV_W-1:0] recovery_ms;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0]  breaker_state;
        logic               allowed;
        logic [COUNT_W-1:0] failure_count;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/fcb_ifs.sv =====
// valid/ready channels for request and result words
`default_nettype none

interface fcb_req_if;
    logic                                valid;
    logic                                ready;
    logic [fcb_pkg::ACTION_W-1:0]        action;
    logic [fcb_pkg::TIME_W-1:0]          now_ms;

    modport source (output valid, output action, output now_ms, input ready);
    modport sink   (input valid, input action, input now_ms, output ready);
endinterface

interface fcb_res_if;
    logic                                valid;
    logic                                ready;
    logic [fcb_pkg::MODE_W-1:0]          breaker_state;
    logic                                allowed;
    logic [fcb_pkg::COUNT_W-1:0]         failure_count;

    modport source (output valid, output breaker_state, output allowed,
                    output failure_count, input ready);
    modport sink   (input valid, input breaker_state, input allowed,
                    input failure_count, output ready);
endinterface

`default_nettype wire

// ===== sv/fcb_cfg.sv =====
// configuration registers of the breaker
`default_nettype none

module fcb_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fcb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [fcb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output fcb_pkg::t_cfg                          o_cfg
);

    fcb_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.failure_limit <= fcb_pkg::LIMIT_RST;
            r_cfg.recovery_ms   <= fcb_pkg::RECOVERY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fcb_pkg::CFG_FAILURE_LIMIT: begin
                    r_cfg.failure_limit <= i_cfg_wdata[fcb_pkg::LIMIT_W-1:0];
                end
                fcb_pkg::CFG_RECOVERY_MS: begin
                    r_cfg.recovery_ms <= i_cfg_wdata[fcb_pkg::RECOV_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/fcb_engine.sv =====
// breaker state and the next-state logic for one word
`default_nettype none

module fcb_engine (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_adv,
    input  wire logic [fcb_pkg::ACTION_W-1:0]    i_action,
    input  wire logic [fcb_pkg::TIME_W-1:0]      i_now_ms,
    input  wire fcb_pkg::t_cfg                   i_cfg,
    output fcb_pkg::t_result                     o_result
);

    logic [fcb_pkg::MODE_W-1:0]  r_mode,  n_mode;
    logic [fcb_pkg::COUNT_W-1:0] r_fail,  n_fail;
    logic [fcb_pkg::PROBE_W-1:0] r_probe, n_probe;
    logic [fcb_pkg::TIME_W-1:0]  r_last,  n_last;

    logic [fcb_pkg::TIME_W-1:0]  elapsed;
    logic [fcb_pkg::PROBE_W-1:0] probe_inc;
    logic [fcb_pkg::COUNT_W-1:0] fail_inc;

    // wraps modulo 2^48 by width
    assign elapsed   = i_now_ms - r_last;
    assign probe_inc = r_probe + fcb_pkg::PROBE_W'(1);
    assign fail_inc  = (r_fail != '1) ? r_fail + fcb_pkg::COUNT_W'(1) : r_fail;

    always_comb begin
        n_mode  = r_mode;
        n_fail  = r_fail;
        n_probe = r_probe;
        n_last  = r_last;
        unique case (i_action)
            fcb_pkg::ACT_QUERY: begin
                if (r_mode == fcb_pkg::MODE_OPEN &&
                    elapsed >= fcb_pkg::TIME_W'(i_cfg.recovery_ms)) begin
                    n_mode = fcb_pkg::MODE_HALF;
                end
            end
            fcb_pkg::ACT_SUCCESS: begin
                if (r_mode == fcb_pkg::MODE_HALF) begin
                    if (probe_inc >= fcb_pkg::CLOSE_SUCCESSES) begin
                        n_mode  = fcb_pkg::MODE_CLOSED;
                        n_fail  = '0;
                        n_probe = '0;
                    end else begin
                        n_probe = probe_inc;
                    end
                end else if (r_fail != '0) begin
                    n_fail = r_fail - fcb_pkg::COUNT_W'(1);
                end
            end
            fcb_pkg::ACT_FAILURE: begin
                n_fail  = fail_inc;
                n_last  = i_now_ms;
                n_probe = '0;
                if (fail_inc >= i_cfg.failure_limit) begin
                    n_mode = fcb_pkg::MODE_OPEN;
                end
            end
            default: begin
                n_mode  = fcb_pkg::MODE_CLOSED;
                n_fail  = '0;
                n_probe = '0;
                n_last  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= fcb_pkg::MODE_CLOSED;
            r_fail  <= '0;
            r_probe <= '0;
            r_last  <= '0;
        end else if (i_adv) begin
            r_mode  <= n_mode;
            r_fail  <= n_fail;
            r_probe <= n_probe;
            r_last  <= n_last;
        end
    end

    assign o_result.breaker_state = n_mode;
    assign o_result.allowed       = (n_mode == fcb_pkg::MODE_CLOSED) ||
                                    (n_mode == fcb_pkg::MODE_HALF);
    assign o_result.failure_count = n_fail;

endmodule

`default_nettype wire

// ===== sv/failure_circuit_breaker.sv =====
// top level of the closed / open / half-open failure circuit breaker
// each request word (action, now_ms) yields exactly one result word holding the
// breaker mode after the action, the allowed flag and the failure count. a word is
// registered on acceptance, the state update and result are worked out between that
// input register and the result register, which loads once it is empty or its
// word is taken. one word is taken every cycle while the result side does not
// stall; the engine works out the next state combinationally, with the result
// register holding a finished word while the next one is taken.
// the user must write configuration (failure_limit index 0, recovery_ms index 1)
// through the plain write port, only while no word is in flight; the block
// itself does not enforce this
`default_nettype none

module failure_circuit_breaker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fcb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [fcb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    fcb_req_if.sink                                i_req,
    fcb_res_if.source                              o_res
);

    fcb_pkg::t_cfg    cfg;
    fcb_pkg::t_result result;

    // input register
    logic                           r_in_valid;
    logic [fcb_pkg::ACTION_W-1:0]   r_action;
    logic [fcb_pkg::TIME_W-1:0]     r_now_ms;

    // result register
    logic                           r_out_valid;
    fcb_pkg::t_result               r_out;

    logic out_load;   // result register can take a word
    logic adv;        // word in the input register is processed this cycle

    assign out_load    = !r_out_valid || o_res.ready;
    assign adv         = r_in_valid && out_load;
    assign i_req.ready = !r_in_valid || adv;

    fcb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // breaker state lives in the engine and moves only when a word advances
    fcb_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_action (r_action),
        .i_now_ms (r_now_ms),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_action <= i_req.action;
            r_now_ms <= i_req.now_ms;
        end
    end

    // result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.breaker_state = r_out.breaker_state;
    assign o_res.allowed       = r_out.allowed;
    assign o_res.failure_count = r_out.failure_count;

endmodule

`default_nettype wire

// ===== test/fcb_checker.sv =====
// checker for the failure circuit breaker: watches both channels, predicts and compares
`default_nettype none

module fcb_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fcb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [fcb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    fcb_req_if                                  i_req,
    fcb_res_if                                  i_res,
    output int unsigned                         o_fail_count,
    output int unsigned                         o_pending,
    output int unsigned                         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import fcb_pkg::*;

    typedef struct {
        t_result     outcome;
        int unsigned index;
    } t_expected_word;

    t_expected_word      expected_q[$];
    logic [MODE_W-1:0]   brk_mode;
    logic [COUNT_W-1:0]  fail_cnt;
    logic [PROBE_W-1:0]  probe_cnt;
    logic [TIME_W-1:0]   last_fail_ms;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [RECOV_W-1:0]  recovery_reg;
    int unsigned         words_in;

    function automatic void clear_breaker();
        brk_mode     = MODE_CLOSED;
        fail_cnt     = '0;
        probe_cnt    = '0;
        last_fail_ms = '0;
    endfunction

    // advances the breaker by one word and returns the result it should give
    function automatic t_result predict_breaker(input logic [ACTION_W-1:0] act,
                                                input logic [TIME_W-1:0] now);
        t_result           r;
        logic [TIME_W-1:0] elapsed;
        case (act)
            ACT_QUERY: begin
                elapsed = now - last_fail_ms;
                if (brk_mode == MODE_OPEN && elapsed >= TIME_W'(recovery_reg))
                    brk_mode = MODE_HALF;
            end
            ACT_SUCCESS: begin
                if (brk_mode == MODE_HALF) begin
                    probe_cnt = probe_cnt + 1'b1;
                    if (probe_cnt >= CLOSE_SUCCESSES) begin
                        brk_mode  = MODE_CLOSED;
                        fail_cnt  = '0;
                        probe_cnt = '0;
                    end
                end else if (fail_cnt != '0) begin
                    fail_cnt = fail_cnt - 1'b1;
                end
            end
            ACT_FAILURE: begin
                if (fail_cnt != '1)
                    fail_cnt = fail_cnt + 1'b1;
                last_fail_ms = now;
                probe_cnt    = '0;
                if (fail_cnt >= limit_reg)
                    brk_mode = MODE_OPEN;
            end
            ACT_CLEAR: clear_breaker();
            default: ;
        endcase
        r.breaker_state = brk_mode;
        r.allowed       = (brk_mode == MODE_CLOSED) || (brk_mode == MODE_HALF);
        r.failure_count = fail_cnt;
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        words_in     = 0;
    end

    always @(posedge i_clk) begin
        t_result        got;
        t_expected_word head;
        if (!i_rst_n) begin
            limit_reg    = LIMIT_RST;
            recovery_reg = RECOVERY_RST;
            clear_breaker();
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FAILURE_LIMIT)
                    limit_reg = i_cfg_wdata[LIMIT_W-1:0];
                else if (i_cfg_idx == CFG_RECOVERY_MS)
                    recovery_reg = i_cfg_wdata[RECOV_W-1:0];
            end
            // results first: a result at this edge never belongs to a word taken at it
            if (i_res.valid && i_res.ready) begin
                got.breaker_state = i_res.breaker_state;
                got.allowed       = i_res.allowed;
                got.failure_count = i_res.failure_count;
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result with nothing expected: %s %0d %0d %0d",
                                 $time, "state/allowed/count", got.breaker_state,
                                 got.allowed, got.failure_count);
                end else begin
                    head = expected_q.pop_front();
                    o_checked++;
                    if (got.breaker_state !== head.outcome.breaker_state ||
                        got.allowed       !== head.outcome.allowed ||
                        got.failure_count !== head.outcome.failure_count) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: word %0d expected state %0d allowed %0d count %0d",
                                     $time, head.index, head.outcome.breaker_state,
                                     head.outcome.allowed, head.outcome.failure_count);
                            $display("    got state %0d allowed %0d count %0d",
                                     got.breaker_state, got.allowed, got.failure_count);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                head.outcome = predict_breaker(i_req.action, i_req.now_ms);
                head.index   = words_in;
                words_in++;
                expected_q = {expected_q, head};
            end
        end
        o_pending = expected_q.size();
    end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench top for the failure circuit breaker: clock, reset, stimulus and verdict
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fcb_pkg::*;

    // cycles without any word moving on either channel before the run is called hung
    localparam int unsigned QUIET_LIMIT  = 1000;
    // at least this many random words per traffic mix within one register setting
    localparam int unsigned PHASE_WORDS  = 18;
    // failures in a row at the widest limit, staying well below it
    localparam int unsigned WIDE_FAILURES = 20;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    fcb_req_if req_ch ();
    fcb_res_if res_ch ();

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    // traffic shaping, in percent of cycles
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    int unsigned words_sent   = 0;
    int unsigned settings_run = 0;

    // what the stimulus side knows of the breaker, only used to aim the times
    logic [LIMIT_W-1:0] cur_limit    = LIMIT_RST;
    logic [RECOV_W-1:0] cur_recovery = RECOVERY_RST;
    logic [TIME_W-1:0]  clock_ms     = '0;
    logic [TIME_W-1:0]  last_trip_ms = '0;

    failure_circuit_breaker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    fcb_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side back-pressure, redrawn every falling edge
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // hang detector: any accepted word on either side restarts the count
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no word moved for %0d cycles", QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // offers one request word, with random idle cycles in front of it, and returns
    // at the falling edge after it has been taken; valid stays high for the next one
    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid  = 1'b1;
        req_ch.action = act;
        req_ch.now_ms = t;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
        clock_ms = t;
        if (act == ACT_FAILURE)
            last_trip_ms = t;
    endtask

    // sender holds off until every result in flight has come back
    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // registers only change with the pipe empty; the upper half of the limit word
    // may carry junk, only the low 16 bits count
    task automatic apply_setting(input logic [CFG_DATA_W-1:0] limit_word,
                                 input logic [RECOV_W-1:0] rec);
        wait_drained();
        write_reg(CFG_FAILURE_LIMIT, limit_word);
        write_reg(CFG_RECOVERY_MS, rec);
        cur_limit    = limit_word[LIMIT_W-1:0];
        cur_recovery = rec;
        settings_run++;
    endtask

    // the well-formed path: trip the breaker, probe just before and at the recovery
    // point, then three successes, now and then broken by a failure mid-probe
    task automatic run_recovery_sequence();
        int unsigned trips;
        int unsigned interrupt_at;
        trips = (cur_limit == 0) ? 1 : ((cur_limit > 8) ? 8 : cur_limit);
        repeat (trips)
            send_word(ACT_FAILURE, clock_ms + $urandom_range(0, 3));
        if (cur_recovery != 0)
            send_word(ACT_QUERY, last_trip_ms + cur_recovery - 1);
        send_word(ACT_QUERY, last_trip_ms + cur_recovery + $urandom_range(0, 1));
        interrupt_at = $urandom_range(0, 11);
        for (int n = 0; n < 3; n++) begin
            if (n == interrupt_at)
                send_word(ACT_FAILURE, clock_ms + $urandom_range(0, 3));
            send_word(ACT_SUCCESS, clock_ms + $urandom_range(0, 3));
        end
    endtask

    // a few loose words: any action, times near now, near the recovery point,
    // or anywhere in the 48-bit range (which also sends time backwards)
    task automatic run_noise();
        logic [ACTION_W-1:0] act;
        logic [TIME_W-1:0]   t;
        int unsigned         pick;
        repeat ($urandom_range(1, 4)) begin
            act  = ACTION_W'($urandom_range(0, 3));
            pick = $urandom_range(0, 3);
            if (pick < 2)
                t = clock_ms + $urandom_range(0, 3);
            else if (pick == 2)
                t = TIME_W'({$urandom(), $urandom()});
            else
                t = last_trip_ms + cur_recovery + $urandom_range(0, 2) - 1;
            send_word(act, t);
        end
    endtask

    // one register setting, run through the four traffic mixes in turn
    task automatic run_setting(input logic [CFG_DATA_W-1:0] limit_word,
                               input logic [RECOV_W-1:0] rec);
        int unsigned first;
        apply_setting(limit_word, rec);
        for (int p = 0; p < 4; p++) begin
            idle_pct  = (p == 1) ? 61 : ((p == 3) ? 18 : 0);
            stall_pct = (p == 2) ? 61 : ((p == 3) ? 18 : 0);
            first     = words_sent;
            while (words_sent - first < PHASE_WORDS) begin
                if ($urandom_range(0, 29) == 0)
                    wait_drained();
                if ($urandom_range(0, 99) < 60)
                    run_recovery_sequence();
                else
                    run_noise();
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_FAILURE_LIMIT;
        i_cfg_wdata   = '0;
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_QUERY;
        req_ch.now_ms = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed walk at the reset settings (limit 5, recovery 30000)
        send_word(ACT_QUERY, 48'd0);                  // closed, nothing to do
        send_word(ACT_SUCCESS, 48'd0);                // count already zero, stays zero
        for (int n = 0; n < 5; n++)
            send_word(ACT_FAILURE, 48'd100 + n);      // opens on the fifth
        send_word(ACT_SUCCESS, 48'd105);              // success while open: count down, still open
        send_word(ACT_SUCCESS, 48'd106);
        send_word(ACT_QUERY, 48'd30103);              // one short of recovery, stays open
        send_word(ACT_QUERY, 48'd30104);              // exactly at recovery, half-open
        send_word(ACT_FAILURE, 48'd30105);            // half-open failure below the limit
        send_word(ACT_SUCCESS, 48'd30106);            // one probe success
        send_word(ACT_FAILURE, 48'd30107);            // reaches the limit, reopens
        send_word(ACT_QUERY, 48'hFFFF_FFFF_FFFF);     // top of the time range
        for (int n = 0; n < 3; n++)
            send_word(ACT_SUCCESS, 48'hFFFF_FFFF_FFFF); // three probes close it
        for (int n = 0; n < 5; n++)
            send_word(ACT_FAILURE, 48'hFFFF_FFFF_FFF0);
        send_word(ACT_QUERY, 48'hFFFF_FFFF_FFEF);     // time went back: huge elapsed time
        send_word(ACT_CLEAR, 48'h8000_0000_0001);

        // widest settings, no gaps on either side: a failure run stays below the limit
        apply_setting(32'h0000_FFFF, 32'hFFFF_FFFF);
        for (int unsigned n = 0; n < WIDE_FAILURES; n++)
            send_word(ACT_FAILURE, TIME_W'(n));
        send_word(ACT_QUERY, clock_ms);               // still closed, no time check
        send_word(ACT_SUCCESS, clock_ms);             // count down by one
        send_word(ACT_FAILURE, clock_ms + 1);
        send_word(ACT_CLEAR, clock_ms + 2);

        // random part: smallest and largest values among the settings,
        // zero limit and zero recovery included
        run_setting(32'd1, 32'd1);
        run_setting(32'd0, 32'd0);
        run_setting(32'h5A5A_0003, 32'd1000);
        run_setting(32'd2, 32'hFFFF_FFFF);
        run_setting(32'hFFFF_0006, 32'd7);
        run_setting(32'd5, 32'd30000);

        // let the last results out, then idle the clock for anything stray
        wait_drained();
        repeat (8) @(negedge i_clk);

        $display("sent %0d request words over %0d register settings: %s",
                 words_sent, settings_run,
                 "directed walk, widest settings and random trip/recover traffic");
        $display("checked %0d results under %s, %0d mismatches",
                 checked, "no gaps, sender gaps, receiver stalls and both", fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
